FILE: hdl/assert_macros.svh
// assertion macros shared by the rssi level tracker rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RLT_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant violated");
`define RLT_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication violated");
`else
`define RLT_ASSERT_ALWAYS(lbl, expr)
`define RLT_ASSERT_IMPLIES(lbl, ante, cons)
`endif
`endif

FILE: hdl/rlt_pkg.sv
// constants and types for the rssi level tracker
// no dependencies
package rlt_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int OUT_COUNT_W = 16;
	localparam int DIV_WIDTH = 17;
	localparam int DIV_STEPS = DIV_WIDTH;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [8:0] WEIGHT_MIN = 9'd13;
	localparam logic [8:0] WEIGHT_MAX = 9'd256;
	localparam logic [8:0] WEIGHT_RESET = 9'd77;

	typedef logic [1:0] trend_t;
	localparam trend_t TREND_STABLE = 2'd0;
	localparam trend_t TREND_RISING = 2'd1;
	localparam trend_t TREND_FALLING = 2'd2;

	localparam logic signed [18:0] TREND_STEP = 19'sd384;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: hdl/rssi_level_tracker.sv
// rssi level tracker: peak, lowest, ema, running mean, count and trend
// one word at a time: sample_stall holds off a new word until the previous one is emitted
// every word after the first also waits on the 17-step serial mean divider
// the ema multiply is one registered step shared with the divider start
// asynchronous active-low reset clears the history; weight resets to 77
// depends on rlt_pkg, rlt_div and assert_macros.svh
`include "assert_macros.svh"
module rssi_level_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                weight_valid,
	output logic                                weight_ready,
	input  logic [8:0]                          weight_data,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [7:0]                   sample_level,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [7:0]                   current_level,
	output logic signed [7:0]                   peak_level,
	output logic signed [7:0]                   lowest_level,
	output logic signed [15:0]                  smoothed_level,
	output logic signed [15:0]                  mean_level,
	output logic [rlt_pkg::OUT_COUNT_W-1:0]     sample_count,
	output rlt_pkg::trend_t                     trend
);
	import rlt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	logic [1:0]              state_q;
	logic [8:0]              weight_q;
	logic                    started_q;
	logic                    result_valid_q;
	logic signed [7:0]       x_q;
	logic signed [7:0]       cur_q;
	logic signed [7:0]       peak_q;
	logic signed [7:0]       low_q;
	logic signed [15:0]      smooth_q;
	logic signed [15:0]      mean_q;
	logic [COUNT_WIDTH-1:0]  count_q;
	trend_t                  trend_q;
	logic signed [26:0]      prod_q;

	logic                    accept;
	logic                    out_free;
	logic                    emit;
	logic signed [15:0]      x_fix;
	logic signed [16:0]      ema_diff;
	logic signed [26:0]      ema_prod;
	logic signed [26:0]      ema_rnd;
	logic signed [18:0]      ema_step;
	logic signed [16:0]      mean_diff;
	logic [DIV_WIDTH-1:0]    mean_mag;
	logic [DIV_WIDTH-1:0]    quo;
	logic signed [17:0]      quo_signed;
	logic [COUNT_WIDTH-1:0]  count_next;
	logic [8:0]              weight_clamped;
	logic                    div_start;
	div_stat_t               div_stat;

	assign accept = sample_valid && !sample_stall;
	assign sample_stall = state_q != ST_IDLE;
	assign out_free = !result_valid_q || !result_stall;
	assign emit = (state_q == ST_EMIT) && out_free;
	assign div_start = (state_q == ST_PREP) && started_q;
	assign weight_ready = 1'b1;

	assign x_fix = {x_q, 8'h00};
	assign ema_diff = {x_fix[15], x_fix} - {smooth_q[15], smooth_q};
	assign ema_prod = $signed({1'b0, weight_q}) * ema_diff;
	assign ema_rnd = prod_q + 27'sd128;
	assign ema_step = ema_rnd[26:8];

	assign mean_diff = {x_fix[15], x_fix} - {mean_q[15], mean_q};
	assign mean_mag = mean_diff[16] ? DIV_WIDTH'(-mean_diff) : DIV_WIDTH'(mean_diff);
	assign quo_signed = mean_diff[16] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

	always_comb begin
		if (!started_q) begin
			count_next = COUNT_WIDTH'(1);
		end else if (count_q == COUNT_MAX) begin
			count_next = count_q;
		end else begin
			count_next = count_q + 1'b1;
		end
	end

	always_comb begin
		if (weight_data < WEIGHT_MIN) begin
			weight_clamped = WEIGHT_MIN;
		end else if (weight_data > WEIGHT_MAX) begin
			weight_clamped = WEIGHT_MAX;
		end else begin
			weight_clamped = weight_data;
		end
	end

	rlt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mean_mag),
		.divisor  (count_next),
		.stat     (div_stat),
		.quotient (quo)
	);

	// sequencer and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			weight_q <= WEIGHT_RESET;
			started_q <= 1'b0;
			result_valid_q <= 1'b0;
			peak_q <= '0;
			low_q <= '0;
			smooth_q <= '0;
			mean_q <= '0;
			count_q <= '0;
		end else begin
			if (weight_valid && weight_ready) begin
				weight_q <= weight_clamped;
			end
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= started_q ? ST_DIV : ST_EMIT;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						started_q <= 1'b1;
						count_q <= count_next;
						if (!started_q) begin
							peak_q <= x_q;
							low_q <= x_q;
							smooth_q <= x_fix;
							mean_q <= x_fix;
						end else begin
							if (x_q > peak_q) begin
								peak_q <= x_q;
							end
							if (x_q < low_q) begin
								low_q <= x_q;
							end
							smooth_q <= smooth_q + ema_step[15:0];
							mean_q <= mean_q + quo_signed[15:0];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// word payload
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample_level;
		end
		if (state_q == ST_PREP) begin
			prod_q <= ema_prod;
		end
		if (emit) begin
			cur_q <= x_q;
			if (!started_q) begin
				trend_q <= TREND_STABLE;
			end else if (ema_step >= TREND_STEP) begin
				trend_q <= TREND_RISING;
			end else if (ema_step <= -TREND_STEP) begin
				trend_q <= TREND_FALLING;
			end else begin
				trend_q <= TREND_STABLE;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign current_level = cur_q;
	assign peak_level = peak_q;
	assign lowest_level = low_q;
	assign smoothed_level = smooth_q;
	assign mean_level = mean_q;
	assign sample_count = OUT_COUNT_W'(count_q);
	assign trend = trend_q;

	`RLT_ASSERT_ALWAYS(a_weight_range, weight_q >= WEIGHT_MIN && weight_q <= WEIGHT_MAX)
	`RLT_ASSERT_IMPLIES(a_result_after_start, result_valid_q, started_q && count_q != '0)
	`RLT_ASSERT_IMPLIES(a_div_tracks_state, state_q == ST_DIV, div_stat.busy || div_stat.done)
	`RLT_ASSERT_IMPLIES(a_peak_over_low, started_q, peak_q >= low_q)

endmodule

FILE: hdl/rlt_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on rlt_pkg and assert_macros.svh
`include "assert_macros.svh"
module rlt_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [rlt_pkg::DIV_WIDTH-1:0]     dividend,
	input  logic [rlt_pkg::COUNT_WIDTH-1:0]   divisor,
	output rlt_pkg::div_stat_t                stat,
	output logic [rlt_pkg::DIV_WIDTH-1:0]     quotient
);
	import rlt_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [COUNT_WIDTH-1:0] div_q;
	logic [DIV_WIDTH-1:0]   quo_q;
	logic [COUNT_WIDTH:0]   trial;
	logic [COUNT_WIDTH:0]   trial_sub;
	logic                   ge;

	assign trial = {rem_q, quo_q[DIV_WIDTH-1]};
	assign ge = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
			quo_q <= {quo_q[DIV_WIDTH-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = quo_q;

	`RLT_ASSERT_IMPLIES(a_rem_below_div, busy_q && !$past(start), rem_q < div_q)
	`RLT_ASSERT_IMPLIES(a_done_after_busy, done_q, $past(busy_q) && !busy_q)

endmodule
